// ===== hw/rtl/blue_dominance_frame_detector_assert.svh =====
// Assertion macros for the blue dominance frame detector.
`ifndef BLUE_DOMINANCE_FRAME_DETECTOR_ASSERT_SVH
`define BLUE_DOMINANCE_FRAME_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

`define BDFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdfd assertion failed");

`define BDFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdfd assertion failed");

`else

`define BDFD_ASSERT_IMPL(label, clk, rst, ante, cons)

`define BDFD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/bdfd_pkg.sv =====
// Shared types and constants of the blue dominance frame detector.
package bdfd_pkg;

  localparam int COUNT_WIDTH_DEF    = 22;
  localparam int CERT_FRAC_BITS_DEF = 16;

  localparam int FULL_SCALE = 255;
  localparam int S_W        = 17;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_ONE  = 2'd1;
  localparam logic [1:0] CLS_TWO  = 2'd2;

  typedef struct packed {
    logic [S_W-1:0] ssq;
    logic [1:0]     cls;
    logic           last;
  } pix_t;

endpackage

// ===== hw/rtl/bdfd_front.sv =====
// Front end: accepts pixels, forms the sum of positive squared differences.
module bdfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic              last_pixel,
  output logic              push_valid,
  input  logic              push_ready,
  output bdfd_pkg::pix_t    push_data
);

  localparam int SW = bdfd_pkg::S_W;

  logic        pos1;
  logic        pos2;
  logic [7:0]  d1;
  logic [7:0]  d2;
  logic [15:0] sq1;
  logic [15:0] sq2;
  logic [SW-1:0] ssq;
  logic [1:0]  cls;
  logic        hold_valid;
  bdfd_pkg::pix_t hold;

  always_comb begin
    pos1 = blue > red;
    pos2 = blue > green;
    d1   = pos1 ? (blue - red) : 8'd0;
    d2   = pos2 ? (blue - green) : 8'd0;
    sq1  = d1 * d1;
    sq2  = d2 * d2;
    ssq  = SW'(sq1) + SW'(sq2);
    if (pos1 && pos2) begin
      cls = bdfd_pkg::CLS_TWO;
    end else if (pos1 || pos2) begin
      cls = bdfd_pkg::CLS_ONE;
    end else begin
      cls = bdfd_pkg::CLS_NONE;
    end
  end

  assign in_ready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_data  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold.ssq  <= ssq;
      hold.cls  <= cls;
      hold.last <= last_pixel;
    end
  end

endmodule

// ===== hw/rtl/bdfd_fifo.sv =====
// Short queue of classified pixel words between front and back.
module bdfd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  bdfd_pkg::pix_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bdfd_pkg::pix_t pop_data
);

  `include "blue_dominance_frame_detector_assert.svh"

  localparam int DEPTH = bdfd_pkg::QUEUE_DEPTH;
  localparam int AW    = bdfd_pkg::QUEUE_AW;
  localparam int CW    = bdfd_pkg::QUEUE_CW;

  bdfd_pkg::pix_t  mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `BDFD_ASSERT_IMPL(a_fifo_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `BDFD_ASSERT_NEXT(a_fifo_fill, clk, rst, do_push && !do_pop, count != '0)

endmodule

// ===== hw/rtl/bdfd_cert.sv =====
// Certainty unit: square root of the scaled squared difference, then multiply by 1/255.
module bdfd_cert #(
  parameter int CERT_FRAC_BITS = bdfd_pkg::CERT_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pix_valid,
  output logic                    pix_ready,
  input  bdfd_pkg::pix_t          pix,
  output logic                    cert_valid,
  input  logic                    cert_ready,
  output logic [CERT_FRAC_BITS:0] cert,
  output logic                    cert_last
);

  `include "blue_dominance_frame_detector_assert.svh"

  localparam int F     = CERT_FRAC_BITS;
  localparam int SW    = bdfd_pkg::S_W;
  localparam int E1    = 2 * F + 2;
  localparam int E2    = 2 * F + 1;
  localparam int YW    = 2 * F + 18;
  localparam int RTW   = F + 9;
  localparam int SH    = RTW + 8;
  localparam int KW    = F + 10;
  localparam int PW    = RTW + KW;
  localparam int MW    = F + 2;
  localparam int CW    = F + 1;
  localparam int CNT_W = $clog2(RTW + 1);
  localparam longint unsigned FS    = longint'(bdfd_pkg::FULL_SCALE);
  localparam longint unsigned RECIP = ((64'd1 << SH) + FS - 64'd1) / FS;
  localparam logic [KW-1:0]   K     = KW'(RECIP);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SQRT  = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [YW-1:0]    v;
  logic [YW-1:0]    res;
  logic [YW-1:0]    probe;
  logic [CW-1:0]    cert_q;
  logic             last_q;

  logic [YW:0]      trial;
  logic             take;
  logic [YW-1:0]    res_next;
  logic [PW-1:0]    prod;
  logic [MW-1:0]    m_inc;

  // root/255 by reciprocal, exact for any root below 2^RTW
  always_comb begin
    trial    = {1'b0, res} + {1'b0, probe};
    take     = {1'b0, v} >= trial;
    res_next = take ? ((res >> 1) + probe) : (res >> 1);
    prod     = PW'(res[RTW-1:0]) * PW'(K);
    m_inc    = prod[SH +: MW] + MW'(1);
  end

  assign pix_ready  = state == ST_IDLE;
  assign cert_valid = state == ST_DONE;
  assign cert       = cert_q;
  assign cert_last  = last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pix_valid) begin
            last_q <= pix.last;
            if (pix.cls == bdfd_pkg::CLS_NONE) begin
              cert_q <= '0;
              state  <= ST_DONE;
            end else begin
              res   <= '0;
              probe <= {2'b01, {(YW-2){1'b0}}};
              cnt   <= CNT_W'(RTW);
              state <= ST_SQRT;
              if (pix.cls == bdfd_pkg::CLS_ONE) begin
                v <= {pix.ssq[SW-2:0], {E1{1'b0}}};
              end else begin
                v <= {pix.ssq, {E2{1'b0}}};
              end
            end
          end
        end
        ST_SQRT: begin
          if (take) begin
            v <= v - trial[YW-1:0];
          end
          res   <= res_next;
          probe <= probe >> 2;
          if (cnt == CNT_W'(1)) begin
            state <= ST_SCALE;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_SCALE: begin
          cert_q <= m_inc[MW-1:1];
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (cert_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `BDFD_ASSERT_IMPL(a_cert_cnt, clk, rst, state == ST_SQRT, cnt != '0)
  `BDFD_ASSERT_NEXT(a_cert_sqrt_end, clk, rst, state == ST_SQRT && cnt == CNT_W'(1), state == ST_SCALE)

endmodule

// ===== hw/rtl/bdfd_accum.sv =====
// Back end: saturating certainty sum and pixel count, frame decision, result register.
module bdfd_accum #(
  parameter int COUNT_WIDTH    = bdfd_pkg::COUNT_WIDTH_DEF,
  parameter int CERT_FRAC_BITS = bdfd_pkg::CERT_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cert_valid,
  output logic                    cert_ready,
  input  logic [CERT_FRAC_BITS:0] cert,
  input  logic                    cert_last,
  input  logic [CERT_FRAC_BITS:0] threshold,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    detected,
  output logic [COUNT_WIDTH:0]    pixel_count,
  output logic                    overflow
);

  `include "blue_dominance_frame_detector_assert.svh"

  localparam int SUMW = COUNT_WIDTH + CERT_FRAC_BITS + 1;
  localparam int CNW  = COUNT_WIDTH + 1;
  localparam int PW   = SUMW + 1;

  localparam logic [1:0] ST_ACC = 2'd0;
  localparam logic [1:0] ST_MUL = 2'd1;
  localparam logic [1:0] ST_CMP = 2'd2;

  logic [1:0]      state;
  logic [SUMW-1:0] sum;
  logic [CNW-1:0]  count;
  logic            flag;
  logic [PW-1:0]   prod;
  logic [SUMW:0]   sum_add;
  logic            take_cert;
  logic            emit;

  assign cert_ready = state == ST_ACC;
  assign take_cert  = cert_valid && cert_ready;
  assign emit       = state == ST_CMP && (!out_valid || out_ready);
  assign sum_add    = {1'b0, sum} + (SUMW + 1)'(cert);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      sum       <= '0;
      count     <= '0;
      flag      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_ACC: begin
          if (take_cert) begin
            if (!count[COUNT_WIDTH]) begin
              count <= count + CNW'(1);
            end
            if (sum_add[SUMW]) begin
              sum <= '1;
            end else begin
              sum <= sum_add[SUMW-1:0];
            end
            if (count[COUNT_WIDTH] || sum_add[SUMW]) begin
              flag <= 1'b1;
            end
            if (cert_last) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (emit) begin
            sum   <= '0;
            count <= '0;
            flag  <= 1'b0;
            state <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= PW'(threshold) * PW'(count);
    end
    if (emit) begin
      detected    <= {1'b0, sum} > prod;
      pixel_count <= count;
      overflow    <= flag;
    end
  end

  `BDFD_ASSERT_NEXT(a_acc_last, clk, rst, take_cert && cert_last, state == ST_MUL)
  `BDFD_ASSERT_NEXT(a_acc_clear, clk, rst, emit, out_valid && count == '0 && sum == '0 && !flag)

endmodule

// ===== hw/rtl/blue_dominance_frame_detector.sv =====
// Top level of the blue dominance frame detector.
// The front end takes one pixel word per cycle into a four-word queue while
// the queue has room; the certainty unit behind it works on one pixel at a
// time. A pixel with no positive blue difference goes straight to the done
// state there; any other passes through the two-bits-per-cycle square root
// of the scaled squared difference and then the reciprocal multiply by
// 1/255. The last pixel of a frame is followed by the threshold multiply
// and then the compare before the result word is registered. The
// accumulator keeps working while a result word waits to be taken. The
// threshold resets to one half and is written through the cfg port, which
// is always ready.
module blue_dominance_frame_detector #(
  parameter int COUNT_WIDTH    = bdfd_pkg::COUNT_WIDTH_DEF,
  parameter int CERT_FRAC_BITS = bdfd_pkg::CERT_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CERT_FRAC_BITS:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              red,
  input  logic [7:0]              green,
  input  logic [7:0]              blue,
  input  logic                    last_pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    detected,
  output logic [COUNT_WIDTH:0]    pixel_count,
  output logic                    overflow
);

  logic [CERT_FRAC_BITS:0] threshold;

  logic            push_valid;
  logic            push_ready;
  bdfd_pkg::pix_t  push_data;
  logic            pop_valid;
  logic            pop_ready;
  bdfd_pkg::pix_t  pop_data;
  logic            cert_valid;
  logic            cert_ready;
  logic [CERT_FRAC_BITS:0] cert;
  logic            cert_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= {2'b01, {(CERT_FRAC_BITS-1){1'b0}}};
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  bdfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .last_pixel (last_pixel),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bdfd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bdfd_cert #(
    .CERT_FRAC_BITS (CERT_FRAC_BITS)
  ) u_cert (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pop_valid),
    .pix_ready  (pop_ready),
    .pix        (pop_data),
    .cert_valid (cert_valid),
    .cert_ready (cert_ready),
    .cert       (cert),
    .cert_last  (cert_last)
  );

  bdfd_accum #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .CERT_FRAC_BITS (CERT_FRAC_BITS)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .cert_valid  (cert_valid),
    .cert_ready  (cert_ready),
    .cert        (cert),
    .cert_last   (cert_last),
    .threshold   (threshold),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .detected    (detected),
    .pixel_count (pixel_count),
    .overflow    (overflow)
  );

endmodule
